### hdl/vertex_skinning_blend_defines.svh
// ----------------------------------------------------------------------------
// vertex_skinning_blend_defines
// Assertion macros shared by the skinning blend RTL.
// ----------------------------------------------------------------------------
`ifndef VERTEX_SKINNING_BLEND_DEFINES_SVH
`define VERTEX_SKINNING_BLEND_DEFINES_SVH

// checked only out of reset
`define VSB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");

// checked also during reset
`define VSB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m failed");

`endif

### hdl/vsb_pkg.sv
// ----------------------------------------------------------------------------
// vsb_pkg
// Widths, constants and shared types of the skinning blend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package vsb_pkg;
  localparam int DEF_PALETTE_ENTRIES = 64;
  localparam int DEF_INFLUENCES      = 4;
  localparam int MAX_INPUT_LANES     = 4;
  localparam int ELEMS      = 12;
  localparam int WORD_W     = 32;
  localparam int WEIGHT_W   = 17;
  localparam int JOINT_W    = 8;
  localparam int WIDE_W     = 48;
  localparam int TERM_W     = 50;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SKIN  = 1'b1;

  typedef struct packed {
    logic              en;
    logic [7:0]        entry;
    logic [3:0]        element;
    logic [WORD_W-1:0] value;
  } pal_wr_t;
endpackage

### hdl/vsb_lane.sv
// ----------------------------------------------------------------------------
// vsb_lane
// One influence: palette copy, affine transform, weight scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vsb_lane import vsb_pkg::*; #(
  parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
  input  logic                       clk,
  input  pal_wr_t                    wr,
  input  logic                       advance,
  input  logic signed [WORD_W-1:0]   pos [3],
  input  logic [WEIGHT_W-1:0]        weight,
  input  logic [JOINT_W-1:0]         joint,
  input  logic [8:0]                 limit,
  output logic signed [TERM_W-1:0]   term [3]
);
  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [WORD_W-1:0] mem [ELEMS][PALETTE_ENTRIES];
  logic [AW-1:0] wr_addr, rd_addr;
  assign wr_addr = wr.entry[AW-1:0];
  assign rd_addr = joint[AW-1:0];

  logic [WEIGHT_W-1:0] w_sat;
  logic                skip;
  assign w_sat = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
  assign skip  = (weight == '0) || ({1'b0, joint} >= limit);

  // stage A: palette read
  logic signed [WORD_W-1:0] el_a [ELEMS];
  logic signed [WORD_W-1:0] pos_a [3];
  logic [WEIGHT_W-1:0]      w_a, w_b, w_c;
  logic                     skip_a, skip_b, skip_c, skip_d;
  // stage B: products
  logic signed [63:0]        prod_b [9];
  logic signed [WORD_W-1:0]  trans_b [3];
  // stage C: transformed component
  logic signed [WIDE_W-1:0]  t_c [3];
  logic signed [WIDE_W-1:0]  t_next [3];
  // stage D: weighted product
  logic signed [65:0]        wp_d [3];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.element][wr_addr] <= wr.value;
    end
  end

  always_comb begin
    logic signed [63:0] r0, r1, r2;
    logic signed [49:0] s;
    for (int c = 0; c < 3; c++) begin
      r0 = (prod_b[c] + 64'sd32768) >>> 16;
      r1 = (prod_b[3 + c] + 64'sd32768) >>> 16;
      r2 = (prod_b[6 + c] + 64'sd32768) >>> 16;
      s = 50'(r0) + 50'(r1) + 50'(r2) + 50'(trans_b[c]);
      if (s > 50'sh0_7FFF_FFFF_FFFF) begin
        t_next[c] = {1'b0, {(WIDE_W-1){1'b1}}};
      end else if (s < -50'sh0_8000_0000_0000) begin
        t_next[c] = {1'b1, {(WIDE_W-1){1'b0}}};
      end else begin
        t_next[c] = s[WIDE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int e = 0; e < ELEMS; e++) begin
        el_a[e] <= mem[e][rd_addr];
      end
      pos_a  <= pos;
      w_a    <= w_sat;
      skip_a <= skip;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_b[r*3 + c] <= 64'(pos_a[r]) * 64'(el_a[r*3 + c]);
        end
      end
      for (int c = 0; c < 3; c++) begin
        trans_b[c] <= el_a[9 + c];
      end
      w_b    <= w_a;
      skip_b <= skip_a;
      t_c    <= t_next;
      w_c    <= w_b;
      skip_c <= skip_b;
      for (int c = 0; c < 3; c++) begin
        wp_d[c] <= $signed({{18{t_c[c][WIDE_W-1]}}, t_c[c]}) * $signed({49'b0, w_c});
      end
      skip_d <= skip_c;
      for (int c = 0; c < 3; c++) begin
        term[c] <= skip_d ? '0 : TERM_W'((wp_d[c] + 66'sd32768) >>> 16);
      end
    end
  end
endmodule

### hdl/vsb_merge.sv
// ----------------------------------------------------------------------------
// vsb_merge
// Sums the lane terms, saturates to 32 bits, holds the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vsb_merge import vsb_pkg::*; #(
  parameter int LANES = DEF_INFLUENCES
) (
  input  logic                      clk,
  input  logic                      advance,
  input  logic signed [TERM_W-1:0]  term [LANES][3],
  output logic signed [WORD_W-1:0]  sum [3]
);
  logic signed [TERM_W+3:0] acc [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = '0;
      for (int l = 0; l < LANES; l++) begin
        acc[c] = acc[c] + (TERM_W+4)'(term[l][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int c = 0; c < 3; c++) begin
        if (acc[c] > (TERM_W+4)'(32'sh7FFF_FFFF)) begin
          sum[c] <= 32'sh7FFF_FFFF;
        end else if (acc[c] < -(TERM_W+4)'(33'sh0_8000_0000)) begin
          sum[c] <= 32'sh8000_0000;
        end else begin
          sum[c] <= acc[c][WORD_W-1:0];
        end
      end
    end
  end
endmodule

### hdl/vertex_skinning_blend.sv
// ----------------------------------------------------------------------------
// vertex_skinning_blend
// Linear blend skinning, four influences, fixed-point, one lane per influence.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in      | in        | in_valid/in_stall  | command .. joint_indices
// out     | out       | out_valid/out_stall| skinned_x/y/z
// cfg     | in        | cfg_valid/cfg_ready| cfg_data (palette_size)
//
// One transaction per cycle unless the output stalls; a skin result passes the stages
// palette read at accept, then multiply, sum, weight multiply, round, merge.
// Palette writes take effect for the next transaction; no clearing pass.
// Reset clears the pipeline valids and palette_size.
// A stalled output freezes the whole pipeline; in_stall follows it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "vertex_skinning_blend_defines.svh"
module vertex_skinning_blend import vsb_pkg::*; #(
  parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
  parameter int INFLUENCES      = DEF_INFLUENCES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [6:0]                cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      command,
  input  logic [5:0]                entry_index,
  input  logic [3:0]                element_index,
  input  logic signed [31:0]        element_value,
  input  logic signed [31:0]        pos_x,
  input  logic signed [31:0]        pos_y,
  input  logic signed [31:0]        pos_z,
  input  logic [16:0]               weight_0,
  input  logic [16:0]               weight_1,
  input  logic [16:0]               weight_2,
  input  logic [16:0]               weight_3,
  input  logic [31:0]               joint_indices,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        skinned_x,
  output logic signed [31:0]        skinned_y,
  output logic signed [31:0]        skinned_z
);
  localparam int LANES = (INFLUENCES < MAX_INPUT_LANES) ? INFLUENCES : MAX_INPUT_LANES;
  localparam logic [8:0] ENTRIES_LIM = 9'(PALETTE_ENTRIES);

  logic [6:0] palette_size;
  logic [4:0] vld;
  logic       advance, accept;
  logic [8:0] limit;
  pal_wr_t    wr;

  logic signed [WORD_W-1:0] pos [3];
  logic [WEIGHT_W-1:0]      weights [MAX_INPUT_LANES];
  logic signed [TERM_W-1:0] term [LANES][3];
  logic signed [WORD_W-1:0] sum [3];

  assign cfg_ready = 1'b1;
  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;
  assign accept    = in_valid && advance;
  assign limit     = ({2'b0, palette_size} < ENTRIES_LIM) ? {2'b0, palette_size} : ENTRIES_LIM;

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;
  assign weights[0] = weight_0;
  assign weights[1] = weight_1;
  assign weights[2] = weight_2;
  assign weights[3] = weight_3;

  assign wr.en      = accept && (command == CMD_WRITE) && (element_index < 4'(ELEMS))
                      && ({3'b0, entry_index} < ENTRIES_LIM);
  assign wr.entry   = {2'b0, entry_index};
  assign wr.element = element_index;
  assign wr.value   = element_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= '0;
      vld          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        palette_size <= cfg_data;
      end
      if (advance) begin
        vld       <= {vld[3:0], accept && (command == CMD_SKIN)};
        out_valid <= vld[4];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    vsb_lane #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_lane (
      .clk     (clk),
      .wr      (wr),
      .advance (advance),
      .pos     (pos),
      .weight  (weights[l]),
      .joint   (joint_indices[l*JOINT_W +: JOINT_W]),
      .limit   (limit),
      .term    (term[l])
    );
  end

  vsb_merge #(.LANES(LANES)) u_merge (
    .clk     (clk),
    .advance (advance),
    .term    (term),
    .sum     (sum)
  );

  assign skinned_x = sum[0];
  assign skinned_y = sum[1];
  assign skinned_z = sum[2];

  `VSB_ASSERT(a_merge_to_out, (advance && vld[4]) |=> out_valid)
  `VSB_ASSERT(a_skin_enters, (accept && command == CMD_SKIN) |=> vld[0])
  `VSB_ASSERT(a_out_drop_taken, $fell(out_valid) |-> $past(!out_stall || rst))
  `VSB_ASSERT_ALWAYS(a_no_write_on_stall, in_stall |-> !wr.en)
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vertex_skinning_blend: a clocked driver feeds
// palette writes and skin transactions with random gaps, a clocked monitor
// stalls the output at random and compares each skinned position against an
// in-bench fixed-point blend predictor. palette_size is swept between phases.
// ----------------------------------------------------------------------------
module tb;
  import vsb_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 12;

  typedef struct {
    logic        cmd;
    logic [5:0]  entry;
    logic [3:0]  elem;
    logic [31:0] value;
    logic [31:0] px, py, pz;
    logic [16:0] w [4];
    logic [31:0] joints;
  } vtx_item_t;

  typedef struct {
    logic [31:0] x, y, z;
  } vtx_pos_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = 1'b0;
  logic [5:0]  entry_index = '0;
  logic [3:0]  element_index = '0;
  logic [31:0] element_value = '0;
  logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [16:0] weight_0 = '0, weight_1 = '0, weight_2 = '0, weight_3 = '0;
  logic [31:0] joint_indices = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] skinned_x, skinned_y, skinned_z;

  vertex_skinning_blend u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .entry_index(entry_index), .element_index(element_index),
    .element_value(element_value),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .weight_0(weight_0), .weight_1(weight_1), .weight_2(weight_2), .weight_3(weight_3),
    .joint_indices(joint_indices),
    .out_valid(out_valid), .out_stall(out_stall),
    .skinned_x(skinned_x), .skinned_y(skinned_y), .skinned_z(skinned_z)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  logic [31:0] pal_words [64][12];
  int          joint_limit = 0;

  vtx_item_t item_q [$];
  vtx_pos_t  skinned_q [$];
  int        pending = 0;
  int        errors = 0;
  bit        no_idle = 1'b0;
  int        watchdog = 0;

  function automatic longint round_q16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic vtx_pos_t blend_vertex(vtx_item_t it);
    longint   pos [3];
    longint   acc [3];
    longint   t, w;
    int       j;
    vtx_pos_t r;
    pos[0] = longint'($signed(it.px));
    pos[1] = longint'($signed(it.py));
    pos[2] = longint'($signed(it.pz));
    acc = '{0, 0, 0};
    for (int i = 0; i < 4; i++) begin
      w = longint'(it.w[i]);
      if (w > longint'(WEIGHT_ONE)) w = longint'(WEIGHT_ONE);
      j = int'(it.joints[8*i +: 8]);
      if (w != 0 && j < joint_limit) begin
        for (int c = 0; c < 3; c++) begin
          t = longint'($signed(pal_words[j][9+c]));
          for (int k = 0; k < 3; k++)
            t += round_q16(pos[k] * longint'($signed(pal_words[j][k*3+c])));
          t = clamp(t, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
          acc[c] += round_q16(t * w);
        end
      end
    end
    r.x = 32'(clamp(acc[0], -64'sd2147483648, 64'sd2147483647));
    r.y = 32'(clamp(acc[1], -64'sd2147483648, 64'sd2147483647));
    r.z = 32'(clamp(acc[2], -64'sd2147483648, 64'sd2147483647));
    return r;
  endfunction

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
    endcase
  endfunction

  function automatic logic [16:0] rand_weight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WEIGHT_ONE;
      2:       return 17'($urandom());
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic int gap_len();
    if (no_idle) return 0;
    case ($urandom_range(0, 19))
      0:       return $urandom_range(10, 40);
      1, 2, 3: return $urandom_range(1, 3);
      default: return 0;
    endcase
  endfunction

  task automatic push_write(logic [5:0] e, logic [3:0] el, logic [31:0] v);
    vtx_item_t it;
    it = '{default: '0, w: '{default: '0}};
    it.cmd = CMD_WRITE;
    it.entry = e;
    it.elem = el;
    it.value = v;
    item_q = {item_q, it};
    pending++;
  endtask

  task automatic push_skin(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [16:0] w0, logic [16:0] w1, logic [16:0] w2,
                           logic [16:0] w3, logic [31:0] jn);
    vtx_item_t it;
    it = '{default: '0, w: '{default: '0}};
    it.cmd = CMD_SKIN;
    it.px = x;
    it.py = y;
    it.pz = z;
    it.w = '{w0, w1, w2, w3};
    it.joints = jn;
    it.entry = 6'($urandom());
    it.elem = 4'($urandom());
    it.value = $urandom();
    item_q = {item_q, it};
    pending++;
  endtask

  task automatic push_random_skin();
    logic [31:0] jn;
    for (int b = 0; b < 4; b++)
      jn[8*b +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom())
                                                  : 8'($urandom_range(0, 70));
    push_skin(rand_q16(), rand_q16(), rand_q16(), rand_weight(), rand_weight(),
              rand_weight(), rand_weight(), jn);
  endtask

  task automatic drain();
    while (pending != 0 || skinned_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_palette_size(logic [6:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_valid);
  endtask

  // config accept
  always @(posedge clk) begin
    if (cfg_valid && cfg_ready) begin
      cfg_valid   <= 1'b0;
      joint_limit = (int'(cfg_data) > 64) ? 64 : int'(cfg_data);
    end
  end

  // driver
  int        in_gap = 0;
  vtx_item_t in_cur;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        if (in_cur.cmd == CMD_WRITE) begin
          if (in_cur.elem < 4'd12) pal_words[in_cur.entry][in_cur.elem] = in_cur.value;
        end else begin
          skinned_q = {skinned_q, blend_vertex(in_cur)};
        end
        pending--;
        in_gap = gap_len();
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0 || item_q.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          in_cur = item_q.pop_front();
          in_valid      <= 1'b1;
          command       <= in_cur.cmd;
          entry_index   <= in_cur.entry;
          element_index <= in_cur.elem;
          element_value <= in_cur.value;
          pos_x         <= in_cur.px;
          pos_y         <= in_cur.py;
          pos_z         <= in_cur.pz;
          weight_0      <= in_cur.w[0];
          weight_1      <= in_cur.w[1];
          weight_2      <= in_cur.w[2];
          weight_3      <= in_cur.w[3];
          joint_indices <= in_cur.joints;
        end
      end
    end
  end

  // monitor
  int       stall_len = 0;
  vtx_pos_t exp_pos;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (skinned_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transaction x=%h y=%h z=%h",
                                     skinned_x, skinned_y, skinned_z);
        end else begin
          exp_pos = skinned_q.pop_front();
          if (skinned_x !== exp_pos.x || skinned_y !== exp_pos.y ||
              skinned_z !== exp_pos.z) begin
            errors++;
            if (errors <= 10)
              $display("skin mismatch: exp %h %h %h got %h %h %h", exp_pos.x,
                       exp_pos.y, exp_pos.z, skinned_x, skinned_y, skinned_z);
          end
        end
      end
      if (stall_len > 0) begin
        stall_len--;
        out_stall <= 1'b1;
      end else begin
        stall_len = gap_len();
        out_stall <= (stall_len > 0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || rst)
      watchdog <= 0;
    else if (watchdog >= WATCHDOG_LIMIT) begin
      $display("vertex_skinning_blend: mismatch");
      $finish;
    end else
      watchdog <= watchdog + 1;
  end

  initial begin
    logic [6:0] sizes [8];
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    sizes = '{7'd64, 7'd0, 7'd127, 7'd1, 7'($urandom_range(2, 63)), 7'd65,
              7'($urandom_range(66, 126)), 7'($urandom_range(0, 127))};

    write_palette_size(7'd64);
    for (int e = 0; e < 64; e++)
      for (int el = 0; el < 12; el++)
        push_write(6'(e), 4'(el), rand_q16());
    // extreme matrices in entries 0 and 1, ignored writes
    for (int el = 0; el < 12; el++) begin
      push_write(6'd0, 4'(el), 32'h7FFF_FFFF);
      push_write(6'd1, 4'(el), 32'h8000_0000);
    end
    push_write(6'd2, 4'd15, 32'hFFFF_FFFF);
    push_write(6'd2, 4'd12, 32'h0000_0000);
    push_skin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, WEIGHT_ONE, 17'd0, 17'd0,
              17'd0, 32'h0);
    push_skin(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, WEIGHT_ONE, 17'd0, 17'd0,
              17'd0, 32'h0);
    push_skin(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, WEIGHT_ONE, WEIGHT_ONE, WEIGHT_ONE,
              WEIGHT_ONE, 32'h0101_0101);
    push_skin(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 17'd0, 17'd0, 17'd0, 17'd0,
              32'h0302_0100);
    push_skin(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 17'h1FFFF, 17'h1FFFF, 17'd1,
              17'd32768, 32'h0504_0302);
    push_skin(32'h1234_5678, 32'hFEDC_BA98, 32'h0, WEIGHT_ONE, WEIGHT_ONE, 17'd1, 17'd1,
              32'hFFFF_40_3F);
    push_skin(32'h0, 32'h0, 32'h0, WEIGHT_ONE, 17'd16384, 17'd16384, 17'd16384,
              32'h0A09_0807);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_palette_size(sizes[p]);
      no_idle = (p % 3 == 2);
      for (int n = 0; n < 150; n++) begin
        if ($urandom_range(0, 3) == 0)
          push_write(6'($urandom()), ($urandom_range(0, 15) == 0) ? 4'($urandom_range(12, 15))
                                                               : 4'($urandom_range(0, 11)),
                     rand_q16());
        else
          push_random_skin();
      end
      drain();
    end

    if (errors == 0)
      $display("vertex_skinning_blend: match");
    else
      $display("vertex_skinning_blend: mismatch");
    $finish;
  end

endmodule
